// ----- hdl/cti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types, character codes and the byte-wide CRC-32C update for the
// compact type id hash.
// ----------------------------------------------------------------------------
package cti_pkg;

   // crc-32c, reflected castagnoli
   localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
   localparam logic [31:0] HASH12_MASK = 32'h0000_0FFF;

   // character codes
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_C    = 8'h63;
   localparam logic [7:0] CHAR_V    = 8'h76;
   localparam logic [7:0] CHAR_O    = 8'h6F;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // dot counter saturates here
   localparam logic [2:0] DOT_MAX = 3'd7;

   // input transfer
   typedef struct packed {
      logic [7:0] name_char;
      logic       last_char;
   } req_type;

   // result transfer
   typedef struct packed {
      logic [63:0] type_id;
      logic        id_valid;
   } rsp_type;

   // classified character
   typedef struct packed {
      logic [7:0] name_char;
      logic       last_char;
      logic       is_dot;
      logic       is_digit;
   } cls_type;

   // head of the front queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cls_type item;
   } cls_q_type;

   // one byte into the running crc
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/cti_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cti_front
// Accepts characters, classifies them as dot or digit and holds them in a
// two-entry queue for the hashing back end.
// ----------------------------------------------------------------------------
module cti_front import cti_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   output logic      full,
   input  req_type   req_data,
   output cls_q_type q_head,
   input  logic      q_pop
);

   cls_type    entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       do_push, do_pop;
   cls_type    cls;

   // classify the incoming character
   always_comb begin
      cls.name_char = req_data.name_char;
      cls.last_char = req_data.last_char;
      cls.is_dot    = (req_data.name_char == CHAR_DOT);
      cls.is_digit  = (req_data.name_char >= CHAR_ZERO) && (req_data.name_char <= CHAR_NINE);
   end

   // queue control
   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = q_pop && (count_ff != 2'd0);

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

   // head to the back end
   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.item  = entry_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ----- hdl/cti_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cti_back
// Runs the segment crcs, dot tracking and major version parse, builds the
// identifier on the last character and queues it for the consumer.
// ----------------------------------------------------------------------------
module cti_back import cti_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cls_q_type q_head,
   output logic      q_pop,
   output logic      empty,
   input  logic      pop,
   output rsp_type   rsp_data
);

   logic [31:0] root_ff, root_in;
   logic [31:0] sub_ff, sub_in;
   logic [31:0] first_ff, first_in;
   logic [31:0] second_ff, second_in;
   logic [31:0] snap_first0_ff, snap_first0_in;
   logic [31:0] snap_first1_ff, snap_first1_in;
   logic [31:0] snap_second0_ff, snap_second0_in;
   logic [31:0] snap_second1_ff, snap_second1_in;
   logic [2:0]  dots_ff, dots_in;
   logic [7:0]  acc_ff, acc_in;
   logic        open_ff, open_in;
   logic [7:0]  major_ff, major_in;

   rsp_type     rq_ff [2];
   logic [1:0]  rq_count_ff, rq_count_in;
   logic        rq_wr_ff, rq_wr_in;
   logic        rq_rd_ff, rq_rd_in;
   logic        rq_push, rq_pop;

   cls_type     it;
   logic [31:0] root_fin;
   logic [31:0] sub12, name12;
   rsp_type     result;

   assign it = q_head.item;

   // take a character unless it ends a name and the result queue is full
   assign q_pop = q_head.valid && (!it.last_char || (rq_count_ff != 2'd2));

   // segment state update
   always_comb begin
      root_in         = root_ff;
      sub_in          = sub_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      snap_first0_in  = snap_first0_ff;
      snap_first1_in  = snap_first1_ff;
      snap_second0_in = snap_second0_ff;
      snap_second1_in = snap_second1_ff;
      dots_in         = dots_ff;
      acc_in          = acc_ff;
      open_in         = open_ff;
      major_in        = major_ff;

      if (dots_ff != 3'd0) begin
         first_in = crc_byte(first_ff, it.name_char);
      end
      if (dots_ff >= 3'd2) begin
         second_in = crc_byte(second_ff, it.name_char);
      end

      if (it.is_dot) begin
         // root closes with the fixed suffix at the first dot
         if (dots_ff == 3'd0) begin
            root_in = crc_byte(crc_byte(crc_byte(crc_byte(root_ff, CHAR_C), CHAR_V),
                                        CHAR_O), CHAR_ZERO);
         end
         snap_first0_in  = snap_first1_ff;
         snap_first1_in  = first_ff;
         snap_second0_in = snap_second1_ff;
         snap_second1_in = second_ff;
         major_in        = acc_ff;
         acc_in          = 8'd0;
         open_in         = 1'b1;
         if (dots_ff != DOT_MAX) begin
            dots_in = dots_ff + 3'd1;
         end
      end else begin
         if (dots_ff == 3'd0) begin
            root_in = crc_byte(root_ff, it.name_char);
         end
         if (dots_ff == 3'd1) begin
            sub_in = crc_byte(sub_ff, it.name_char);
         end
         // leading decimal digits, modulo 256
         if (open_ff && it.is_digit) begin
            acc_in = (acc_ff << 3) + (acc_ff << 1) + (it.name_char - CHAR_ZERO);
         end else begin
            open_in = 1'b0;
         end
      end
   end

   // identifier from the updated state
   always_comb begin
      root_fin = root_in ^ CRC_INIT;
      if (dots_in == 3'd3) begin
         sub12  = 32'd0;
         name12 = (snap_first0_in ^ CRC_INIT) & HASH12_MASK;
      end else begin
         sub12  = (sub_in ^ CRC_INIT) & HASH12_MASK;
         name12 = (snap_second0_in ^ CRC_INIT) & HASH12_MASK;
      end
      if (dots_in >= 3'd3) begin
         result.type_id  = {root_fin, sub12[11:0], name12[11:0], major_in};
         result.id_valid = 1'b1;
      end else begin
         result.type_id  = 64'd0;
         result.id_valid = 1'b0;
      end
   end

   // state registers, cleared after each name
   always_ff @(posedge clock) begin
      if (reset || (q_pop && it.last_char)) begin
         root_ff         <= CRC_INIT;
         sub_ff          <= CRC_INIT;
         first_ff        <= CRC_INIT;
         second_ff       <= CRC_INIT;
         snap_first0_ff  <= 32'd0;
         snap_first1_ff  <= 32'd0;
         snap_second0_ff <= 32'd0;
         snap_second1_ff <= 32'd0;
         dots_ff         <= 3'd0;
         acc_ff          <= 8'd0;
         open_ff         <= 1'b1;
         major_ff        <= 8'd0;
      end else if (q_pop) begin
         root_ff         <= root_in;
         sub_ff          <= sub_in;
         first_ff        <= first_in;
         second_ff       <= second_in;
         snap_first0_ff  <= snap_first0_in;
         snap_first1_ff  <= snap_first1_in;
         snap_second0_ff <= snap_second0_in;
         snap_second1_ff <= snap_second1_in;
         dots_ff         <= dots_in;
         acc_ff          <= acc_in;
         open_ff         <= open_in;
         major_ff        <= major_in;
      end
   end

   // result queue control
   assign rq_push = q_pop && it.last_char;
   assign rq_pop  = pop && (rq_count_ff != 2'd0);
   assign empty   = (rq_count_ff == 2'd0);

   always_comb begin
      rq_wr_in = rq_push ? !rq_wr_ff : rq_wr_ff;
      rq_rd_in = rq_pop ? !rq_rd_ff : rq_rd_ff;
      case ({rq_push, rq_pop})
         2'b10:   rq_count_in = rq_count_ff + 2'd1;
         2'b01:   rq_count_in = rq_count_ff - 2'd1;
         default: rq_count_in = rq_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_count_ff <= 2'd0;
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
      end else begin
         rq_count_ff <= rq_count_in;
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= result;
      end
   end

   assign rsp_data = rq_ff[rq_rd_ff];

endmodule
`default_nettype wire

// ----- hdl/compact_type_id_hash.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// compact_type_id_hash
// Hashes a dotted data type name, one character per transfer, into a 64-bit
// compact identifier built from segment CRC-32C values and the major version.
//
//   channel   ports                         direction  transfer when
//   req       push, full, req_data          in         push && !full
//   rsp       empty, pop, rsp_data          out        pop && !empty
//
// One character per cycle sustained; a full result queue stalls only the
// last character of a name. A character reaches the crc stage from the head
// of a two-entry front queue, and a name's result is written into a
// two-entry result queue when its last character is hashed. The byte-wide
// crc update with the folded four-byte suffix sets the path. Reset clears
// the queues and the segment state; all hashing state also returns to its
// reset value after every last character.
// ----------------------------------------------------------------------------
module compact_type_id_hash import cti_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   cls_q_type q_head;
   logic      q_pop;

   // accept and classify
   cti_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   // hash and build results
   cti_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
